// ===== hw/rtl/salt_pkg.sv =====
// Shared constants, codes and types for the set-associative LRU cache tracker.
`default_nettype none

package salt_pkg;

   localparam int ADDR_W  = 64;
   localparam int TAG_W   = 64;
   localparam int STAMP_W = 32;
   localparam int CNT_W   = 32;
   localparam int LINE_W  = 1 + TAG_W + STAMP_W;

   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;

   localparam logic [2:0] SET_BITS_RESET   = 3'd0;
   localparam logic [5:0] BLOCK_BITS_RESET = 6'd0;
   localparam logic [3:0] WAYS_RESET       = 4'd1;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STORE  = 2'd1,
      OP_MODIFY = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_BLOCK_BITS = 2'd1,
      CSR_WAYS       = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/set_assoc_cache_lru_tracker_core.sv =====
// Top level: set-associative cache hit/miss/eviction tracker with LRU replacement.
// The edge that accepts start enters the lookup state; the result strobe is registered from that state.
// A new item is taken only in the idle state, once the set row of the last one is read and written back.
// Reset: synchronous; afterwards a clearing pass over all 2**MAX_SET_BITS set rows (64 by
// default) zeroes the set memory while busy stays high. The receiver cannot stall.
`default_nettype none

module set_assoc_cache_lru_tracker_core #(
   parameter int MAX_SET_BITS = salt_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = salt_pkg::DEF_MAX_WAYS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_op,
   input  wire logic [salt_pkg::ADDR_W-1:0] req_address,
   output logic                             rsp_strobe,
   output logic                             rsp_first_hit,
   output logic                             rsp_evicted,
   output logic [1:0]                       rsp_hits_this_item,
   output logic [salt_pkg::CNT_W-1:0]       rsp_hit_total,
   output logic [salt_pkg::CNT_W-1:0]       rsp_miss_total,
   output logic [salt_pkg::CNT_W-1:0]       rsp_eviction_total,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [5:0]                  csr_data
);
   import salt_pkg::*;

   localparam int SetW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int NumSets = 1 << MAX_SET_BITS;
   localparam int RowW    = MAX_WAYS * LINE_W;
   localparam int WayW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int StampLo = 0;
   localparam int TagLo   = STAMP_W;
   localparam int VldBit  = STAMP_W + TAG_W;

   // Configuration registers.
   logic [2:0] set_bits_ff;
   logic [5:0] block_bits_ff;
   logic [3:0] ways_ff;

   state_type state_ff, state_in;
   logic [SetW-1:0]    clr_idx_ff, clr_idx_in;
   logic [1:0]         op_ff;
   logic [SetW-1:0]    set_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [CNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]   miss_cnt_ff, miss_cnt_in;
   logic [CNT_W-1:0]   evict_cnt_ff, evict_cnt_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic               rsp_first_hit_ff, rsp_first_hit_in;
   logic               rsp_evicted_ff, rsp_evicted_in;
   logic [1:0]         rsp_hits_ff, rsp_hits_in;

   // Set memory: one row holds every way of a set.
   logic [RowW-1:0] set_mem [NumSets];
   logic [RowW-1:0] rd_data_ff;
   logic            mem_we;
   logic [SetW-1:0] mem_waddr;
   logic [RowW-1:0] mem_wdata;

   // Address split.
   logic [2:0]        eff_set_bits;
   logic [ADDR_W-1:0] addr_shifted;
   logic [6:0]        tag_shift;
   logic [SetW-1:0]   set_mask;
   logic [SetW-1:0]   set_in;
   logic [TAG_W-1:0]  tag_in;
   logic              accept;

   // Lookup results.
   logic [5:0]         nways;
   logic               hit;
   logic [WayW-1:0]    hit_way;
   logic               have_free;
   logic [WayW-1:0]    free_way;
   logic [STAMP_W-1:0] best_stamp;
   logic [WayW-1:0]    lru_way;
   logic [WayW-1:0]    tgt_way;
   logic [RowW-1:0]    new_row;
   logic               op_is_access;
   logic               op_is_modify;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      if (int'(set_bits_ff) > MAX_SET_BITS) begin
         eff_set_bits = 3'(MAX_SET_BITS);
      end else begin
         eff_set_bits = set_bits_ff;
      end
      addr_shifted = req_address >> block_bits_ff;
      tag_shift    = {1'b0, block_bits_ff} + {4'd0, eff_set_bits};
      set_mask     = ~({SetW{1'b1}} << eff_set_bits);
      set_in       = addr_shifted[SetW-1:0] & set_mask;
      if (tag_shift >= 7'd64) begin
         tag_in = '0;
      end else begin
         tag_in = req_address >> tag_shift[5:0];
      end
   end

   always_comb begin
      if (ways_ff == 4'd0) begin
         nways = 6'd1;
      end else if (int'(ways_ff) > MAX_WAYS) begin
         nways = 6'(MAX_WAYS);
      end else begin
         nways = {2'b00, ways_ff};
      end
   end

   // Tag match, free way and LRU way over the ways in use, then the target way and new row.
   always_comb begin
      hit        = 1'b0;
      hit_way    = '0;
      have_free  = 1'b0;
      free_way   = '0;
      best_stamp = rd_data_ff[StampLo +: STAMP_W];
      lru_way    = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (6'(w) < nways) begin
            if (rd_data_ff[w*LINE_W + VldBit] && !hit &&
                rd_data_ff[w*LINE_W + TagLo +: TAG_W] == tag_ff) begin
               hit     = 1'b1;
               hit_way = WayW'(w);
            end
            if (!rd_data_ff[w*LINE_W + VldBit]) begin
               have_free = 1'b1;
               free_way  = WayW'(w);
            end
            if (w > 0 && rd_data_ff[w*LINE_W + StampLo +: STAMP_W] < best_stamp) begin
               best_stamp = rd_data_ff[w*LINE_W + StampLo +: STAMP_W];
               lru_way    = WayW'(w);
            end
         end
      end
      if (hit) begin
         tgt_way = hit_way;
      end else if (have_free) begin
         tgt_way = free_way;
      end else begin
         tgt_way = lru_way;
      end
      new_row = rd_data_ff;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (tgt_way == WayW'(w)) begin
            new_row[w*LINE_W +: LINE_W] = {1'b1, tag_ff, stamp_ff};
         end
      end
   end

   always_comb begin
      op_is_access = 1'b0;
      op_is_modify = 1'b0;
      case (op_ff)
         OP_LOAD:   op_is_access = 1'b1;
         OP_STORE:  op_is_access = 1'b1;
         OP_MODIFY: begin
            op_is_access = 1'b1;
            op_is_modify = 1'b1;
         end
         default:   op_is_access = 1'b0;
      endcase
   end

   // Next state, memory write and result.
   always_comb begin
      state_in         = state_ff;
      clr_idx_in       = clr_idx_ff;
      stamp_in         = stamp_ff;
      hit_cnt_in       = hit_cnt_ff;
      miss_cnt_in      = miss_cnt_ff;
      evict_cnt_in     = evict_cnt_ff;
      rsp_strobe_in    = 1'b0;
      rsp_first_hit_in = rsp_first_hit_ff;
      rsp_evicted_in   = rsp_evicted_ff;
      rsp_hits_in      = rsp_hits_ff;
      mem_we           = 1'b0;
      mem_waddr        = set_ff;
      mem_wdata        = new_row;
      busy             = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            mem_wdata  = '0;
            clr_idx_in = clr_idx_ff + 1'b1;
            if (clr_idx_ff == SetW'(NumSets - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in         = ST_IDLE;
            stamp_in         = stamp_ff + 1'b1;
            rsp_strobe_in    = 1'b1;
            rsp_first_hit_in = 1'b0;
            rsp_evicted_in   = 1'b0;
            rsp_hits_in      = 2'd0;
            if (op_is_access) begin
               mem_we           = 1'b1;
               rsp_first_hit_in = hit;
               rsp_evicted_in   = !hit && !have_free;
               // The second access of a modify always hits the line just touched.
               rsp_hits_in      = {1'b0, hit} + {1'b0, op_is_modify};
               hit_cnt_in       = hit_cnt_ff + CNT_W'(rsp_hits_in);
               miss_cnt_in      = miss_cnt_ff + CNT_W'(!hit);
               evict_cnt_in     = evict_cnt_ff + CNT_W'(!hit && !have_free);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         set_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= set_mem[set_in];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
      rsp_first_hit_ff <= rsp_first_hit_in;
      rsp_evicted_ff   <= rsp_evicted_in;
      rsp_hits_ff      <= rsp_hits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         stamp_ff      <= '0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         evict_cnt_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
         set_bits_ff   <= SET_BITS_RESET;
         block_bits_ff <= BLOCK_BITS_RESET;
         ways_ff       <= WAYS_RESET;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         stamp_ff      <= stamp_in;
         hit_cnt_ff    <= hit_cnt_in;
         miss_cnt_ff   <= miss_cnt_in;
         evict_cnt_ff  <= evict_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SET_BITS:   set_bits_ff   <= csr_data[2:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_data;
               CSR_WAYS:       ways_ff       <= csr_data[3:0];
               default:        ways_ff       <= ways_ff;
            endcase
         end
      end
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_first_hit      = rsp_first_hit_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_hits_this_item = rsp_hits_ff;
   assign rsp_hit_total      = hit_cnt_ff;
   assign rsp_miss_total     = miss_cnt_ff;
   assign rsp_eviction_total = evict_cnt_ff;

endmodule

`default_nettype wire
